// ===== design/psi_pkg.sv =====
package psi_pkg;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_HDR     = 3'd1;
    localparam logic [2:0] CMD_TGT     = 3'd2;
    localparam logic [2:0] CMD_MEAS    = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;

    localparam int DIV_STEPS = 16;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_HDR,
        OP_TGT,
        OP_MEAS,
        OP_RESTART
    } t_op;

    typedef struct packed {
        logic [2:0]         command;
        logic [23:0]        time_value;
        logic               left_contact;
        logic               right_contact;
        logic [2:0]         state_index;
        logic [2:0]         joint_index;
        logic signed [15:0] angle_a;
        logic signed [15:0] angle_b;
        logic               local_flag;
        logic [2:0]         next_state;
        logic               time_based;
        logic [2:0]         contact_code;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         joint_index_res;
        logic signed [15:0] target_angle;
        logic [2:0]         current_state;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_job;

    typedef struct packed {
        logic [2:0]  next;
        logic        timed;
        logic [2:0]  contact;
        logic [23:0] duration;
    } t_hdr;

    // front -> back handshake
    typedef struct packed {
        logic valid;
        t_job job;
    } t_qout;

endpackage

// ===== design/psi_front.sv =====
module psi_front #(
    parameter int MAX_STATES = 8,
    parameter int NUM_JOINTS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  psi_pkg::t_in_item  i_cmd,
    input  logic               i_pop,
    output psi_pkg::t_qout     o_q
);

    psi_pkg::t_job r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;
    psi_pkg::t_op  op;
    logic          keep;
    logic          push;
    logic          pop;
    logic          si_ok;
    logic          ji_ok;

    assign si_ok = {2'b00, i_cmd.state_index} < 5'(MAX_STATES);
    assign ji_ok = {1'b0, i_cmd.joint_index} < 4'(NUM_JOINTS);

    // drop unknown commands and out-of-range writes here
    always_comb begin
        op   = psi_pkg::OP_TICK;
        keep = 1'b0;
        unique case (i_cmd.command)
            psi_pkg::CMD_TICK: begin
                op = psi_pkg::OP_TICK;    keep = 1'b1;
            end
            psi_pkg::CMD_HDR: begin
                op = psi_pkg::OP_HDR;     keep = si_ok;
            end
            psi_pkg::CMD_TGT: begin
                op = psi_pkg::OP_TGT;     keep = si_ok && ji_ok;
            end
            psi_pkg::CMD_MEAS: begin
                op = psi_pkg::OP_MEAS;    keep = ji_ok;
            end
            psi_pkg::CMD_RESTART: begin
                op = psi_pkg::OP_RESTART; keep = 1'b1;
            end
            default: begin
                op = psi_pkg::OP_TICK;    keep = 1'b0;
            end
        endcase
    end

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy && keep;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= '{op: op, item: i_cmd};
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.job   = r_q[r_rd];

endmodule

// ===== design/psi_back.sv =====
module psi_back #(
    parameter int MAX_STATES = 8,
    parameter int NUM_JOINTS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_state_count,
    input  psi_pkg::t_qout     i_q,
    output logic               o_pop,
    output logic               o_strobe,
    output psi_pkg::t_out_item o_res
);

    localparam int SAW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int JAW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int AW  = SAW + JAW;
    localparam int DCW = $clog2(psi_pkg::DIV_STEPS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TICK = 4'd1;
    localparam logic [3:0] ST_LRD  = 4'd2;
    localparam logic [3:0] ST_LWR  = 4'd3;
    localparam logic [3:0] ST_PRE  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_ERD  = 4'd6;
    localparam logic [3:0] ST_EMUL = 4'd7;
    localparam logic [3:0] ST_EOUT = 4'd8;

    logic [3:0]          r_st;
    logic [2:0]          r_state;
    logic [2:0]          r_next;
    logic [2:0]          r_rd_state;
    logic                r_restart;
    logic [31:0]         r_time;
    logic [JAW-1:0]      r_j;
    logic [24:0]         r_rem;
    logic [16:0]         r_ratio;
    logic [DCW-1:0]      r_dcnt;
    logic                r_direct;
    psi_pkg::t_in_item   r_it;

    logic signed [15:0]  r_start [NUM_JOINTS];
    logic signed [15:0]  r_ml    [NUM_JOINTS];
    logic signed [15:0]  r_mg    [NUM_JOINTS];
    psi_pkg::t_hdr       r_hdr   [MAX_STATES];
    logic [16:0]         r_mem   [2**AW];
    logic [16:0]         r_tgt_q;
    logic                r_tgt_in;

    logic signed [34:0]  r_prod;
    logic signed [15:0]  r_x1;
    logic signed [15:0]  r_x2;
    logic                r_strobe;
    psi_pkg::t_out_item  r_out;

    logic                hold;
    logic [3:0]          cur4;
    logic [3:0]          rd4;
    logic [3:0]          wr4;
    psi_pkg::t_hdr       hdr;
    logic [AW-1:0]       rd_addr;
    logic                rd_ok;
    logic [32:0]         t_sum;
    logic [31:0]         t_new;
    logic                go;
    logic [24:0]         rem2;
    logic [16:0]         tgt;
    logic signed [16:0]  diff;
    logic                j_last;
    logic signed [15:0]  res;

    assign hold   = (i_state_count <= 4'd1);
    assign cur4   = {1'b0, r_state};
    assign rd4    = {1'b0, r_rd_state};
    assign wr4    = {1'b0, i_q.job.item.state_index};
    assign hdr    = ({1'b0, cur4} < 5'(MAX_STATES)) ? r_hdr[cur4[SAW-1:0]] : '0;
    assign rd_ok  = ({1'b0, rd4} < 5'(MAX_STATES));
    assign rd_addr = {rd4[SAW-1:0], r_j};
    assign t_sum  = {1'b0, r_time} + {9'd0, r_it.time_value};
    assign t_new  = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
    assign go     = hdr.timed ? (t_new > {8'd0, hdr.duration})
                              : ({1'b0, r_it.right_contact, r_it.left_contact} == hdr.contact);
    assign rem2   = {r_rem[23:0], 1'b0};
    assign tgt    = r_tgt_in ? r_tgt_q : '0;
    assign diff   = {tgt[15], tgt[15:0]} - {r_x1[15], r_x1};
    assign j_last = (r_j == JAW'(NUM_JOINTS - 1));
    // floor(prod / 65536) only needs its low 16 bits; the sum stays in range
    assign res    = r_direct ? r_x2 : (r_x1 + r_prod[31:16]);

    always_ff @(posedge i_clk) begin
        r_tgt_q  <= r_mem[rd_addr];
        r_tgt_in <= rd_ok;
        if (r_st == ST_IDLE && i_q.valid && i_q.job.op == psi_pkg::OP_TGT)
            r_mem[{wr4[SAW-1:0], i_q.job.item.joint_index[JAW-1:0]}] <=
                {i_q.job.item.local_flag, i_q.job.item.angle_a};
        if (r_st == ST_IDLE && i_q.valid && i_q.job.op == psi_pkg::OP_HDR)
            r_hdr[wr4[SAW-1:0]] <= '{next: i_q.job.item.next_state,
                                     timed: i_q.job.item.time_based,
                                     contact: i_q.job.item.contact_code,
                                     duration: i_q.job.item.time_value};
        if (r_st == ST_IDLE && i_q.valid) r_it <= i_q.job.item;
        if (r_st == ST_EMUL) begin
            r_x1   <= r_start[r_j];
            r_x2   <= tgt[15:0];
            r_prod <= $signed({1'b0, r_ratio}) * $signed({diff[16], diff});
        end else if (r_st == ST_ERD) begin
            r_x1 <= r_start[r_j];
        end
        if (r_st == ST_EOUT) begin
            r_out.joint_index_res <= 3'(r_j);
            r_out.target_angle    <= res;
            r_out.current_state   <= r_state;
            r_out.last            <= j_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_state    <= 3'd0;
            r_next     <= 3'd0;
            r_rd_state <= 3'd0;
            r_restart  <= 1'b0;
            r_time     <= 32'd0;
            r_j        <= '0;
            r_rem      <= '0;
            r_ratio    <= '0;
            r_dcnt     <= '0;
            r_direct   <= 1'b1;
            r_strobe   <= 1'b0;
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_start[k] <= '0;
                r_ml[k]    <= '0;
                r_mg[k]    <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_q.valid) begin
                        unique case (i_q.job.op)
                            psi_pkg::OP_TICK: r_st <= ST_TICK;
                            psi_pkg::OP_MEAS: begin
                                r_ml[i_q.job.item.joint_index[JAW-1:0]] <=
                                    i_q.job.item.angle_a;
                                r_mg[i_q.job.item.joint_index[JAW-1:0]] <=
                                    i_q.job.item.angle_b;
                            end
                            psi_pkg::OP_RESTART: begin
                                r_time     <= 32'd0;
                                r_next     <= 3'd0;
                                r_rd_state <= 3'd0;
                                r_j        <= '0;
                                r_restart  <= 1'b1;
                                r_st       <= ST_LRD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TICK: begin
                    r_j <= '0;
                    if (!hold && go) begin
                        r_time     <= 32'd0;
                        r_next     <= hdr.next;
                        r_rd_state <= hdr.next;
                        r_restart  <= 1'b0;
                        r_st       <= ST_LRD;
                    end else begin
                        r_time     <= t_new;
                        r_rd_state <= r_state;
                        r_st       <= ST_PRE;
                    end
                end
                ST_LRD: r_st <= ST_LWR;
                ST_LWR: begin
                    // restart loads the key pose, a transition the measurement
                    if (r_restart)   r_start[r_j] <= tgt[15:0];
                    else if (tgt[16]) r_start[r_j] <= r_ml[r_j];
                    else             r_start[r_j] <= r_mg[r_j];
                    if (j_last) begin
                        r_j     <= '0;
                        r_state <= r_next;
                        r_st    <= r_restart ? ST_IDLE : ST_PRE;
                    end else begin
                        r_j  <= r_j + 1'b1;
                        r_st <= ST_LRD;
                    end
                end
                ST_PRE: begin
                    r_direct <= hold || !hdr.timed || (hdr.duration == 24'd0);
                    r_ratio  <= 17'h10000;
                    r_rem    <= {1'b0, r_time[23:0]};
                    r_dcnt   <= '0;
                    if (hold || !hdr.timed || (hdr.duration == 24'd0) ||
                        r_time >= {8'd0, hdr.duration})
                        r_st <= ST_ERD;
                    else
                        r_st <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (rem2 >= {1'b0, hdr.duration}) begin
                        r_rem   <= rem2 - {1'b0, hdr.duration};
                        r_ratio <= {r_ratio[15:0], 1'b1};
                    end else begin
                        r_rem   <= rem2;
                        r_ratio <= {r_ratio[15:0], 1'b0};
                    end
                    if (r_dcnt == DCW'(psi_pkg::DIV_STEPS - 1)) r_st <= ST_ERD;
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ST_ERD:  r_st <= ST_EMUL;
                ST_EMUL: r_st <= ST_EOUT;
                ST_EOUT: begin
                    r_strobe <= 1'b1;
                    if (j_last) begin
                        r_j  <= '0;
                        r_st <= ST_IDLE;
                    end else begin
                        r_j  <= r_j + 1'b1;
                        r_st <= ST_ERD;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_pop    = (r_st == ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_out;

endmodule

// ===== design/pose_sequencer_interpolator_top.sv =====
// Keyframe pose sequencer with linear interpolation toward key poses.
// Command channel: an item is taken when start is high and busy is low.
//   Commands fill the header table, the per-joint key targets and the
//   measured angles, restart the sequence, or tick the controller.
// Result channel: only a tick gives results, one per joint, each shown for
//   one cycle with o_strobe; o_res.last marks the final joint. Results
//   cannot be held off by the receiver.
// Config: i_cfg_we/i_cfg_data write state_count; write only when idle.
// A two-entry queue decouples intake from execution; busy is high while
//   it is full.
// Tick processing: the back end pops a tick from the queue when idle,
//   then updates the time and checks for a transition, latches start
//   angles joint by joint when a transition occurs, runs a setup step,
//   the serial Q16 ratio divide when interpolating, and then each joint
//   on the shared multiplier path. Results come joint by joint, in order.
// Restart reloads start angles joint by joint. Reset clears state, time,
//   start and measured angles and sets state_count to one; tables are unset.
module pose_sequencer_interpolator_top #(
    parameter int MAX_STATES = 8,
    parameter int NUM_JOINTS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  psi_pkg::t_in_item  i_cmd,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    output logic               o_strobe,
    output psi_pkg::t_out_item o_res
);

    logic [3:0]     r_state_count;
    psi_pkg::t_qout q;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_state_count <= 4'd1;
        else if (i_cfg_we) r_state_count <= i_cfg_data;
    end

    psi_front #(.MAX_STATES(MAX_STATES), .NUM_JOINTS(NUM_JOINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_pop   (pop),
        .o_q     (q)
    );

    psi_back #(.MAX_STATES(MAX_STATES), .NUM_JOINTS(NUM_JOINTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_state_count (r_state_count),
        .i_q           (q),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_res         (o_res)
    );

endmodule

// ===== design/psi_checker.sv =====
module psi_checker #(
    parameter int NUM_JOINTS = 7
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_strobe,
    input psi_pkg::t_out_item o_res
);

    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("strobe right after reset");

    a_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> !o_strobe) else $error("strobe not one cycle");

    a_joint_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |-> ##3 o_strobe) else $error("joint result missing");

    a_last_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |-> o_res.joint_index_res == 3'(NUM_JOINTS - 1))
        else $error("last flag on wrong joint");

    a_state_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(o_strobe, 3) && !$past(o_res.last, 3)
            |-> o_res.current_state == $past(o_res.current_state, 3))
        else $error("state changed within a tick");

endmodule

bind pose_sequencer_interpolator_top psi_checker #(.NUM_JOINTS(NUM_JOINTS)) u_psi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

// ===== bench/psi_checker.sv =====
`timescale 1ns / 100ps

module psi_scoreboard #(
    parameter int MAX_STATES = 8,
    parameter int NUM_JOINTS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  psi_pkg::t_in_item  i_cmd,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    input  logic               o_strobe,
    input  psi_pkg::t_out_item o_res,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [3:0]         state_count;
    logic [2:0]         pose_state;
    logic [31:0]        dwell_time;
    int                 latch_angle [NUM_JOINTS];
    int                 meas_loc [NUM_JOINTS];
    int                 meas_glb [NUM_JOINTS];
    int                 key_angle [MAX_STATES][NUM_JOINTS];
    logic               key_local [MAX_STATES][NUM_JOINTS];
    psi_pkg::t_hdr      hdr_tab [MAX_STATES];
    psi_pkg::t_out_item joint_targets_q [$];

    assign o_pending = joint_targets_q.size();

    function automatic int lerp_angle(int x1, int x2, logic [31:0] t, logic [23:0] dur);
        longint unsigned ratio;
        longint          prod;
        ratio = ({32'd0, t} << 16) / {40'd0, dur};
        if (ratio > 64'd65536)
            ratio = 64'd65536;
        prod = longint'(ratio) * longint'(x2 - x1);
        return x1 + int'(prod >>> 16);
    endfunction

    task automatic advance_pose(psi_pkg::t_in_item it);
        logic               hold;
        logic               go;
        logic [1:0]         feet;
        psi_pkg::t_hdr      h;
        psi_pkg::t_out_item r;
        int                 x1;
        int                 x2;
        hold = (state_count <= 4'd1);
        case (it.command)
            psi_pkg::CMD_HDR: begin
                hdr_tab[it.state_index].next     = it.next_state;
                hdr_tab[it.state_index].timed    = it.time_based;
                hdr_tab[it.state_index].contact  = it.contact_code;
                hdr_tab[it.state_index].duration = it.time_value;
            end
            psi_pkg::CMD_TGT: begin
                if (it.joint_index < NUM_JOINTS) begin
                    key_angle[it.state_index][it.joint_index] = it.angle_a;
                    key_local[it.state_index][it.joint_index] = it.local_flag;
                end
            end
            psi_pkg::CMD_MEAS: begin
                if (it.joint_index < NUM_JOINTS) begin
                    meas_loc[it.joint_index] = it.angle_a;
                    meas_glb[it.joint_index] = it.angle_b;
                end
            end
            psi_pkg::CMD_RESTART: begin
                pose_state = '0;
                dwell_time = '0;
                for (int j = 0; j < NUM_JOINTS; j++)
                    latch_angle[j] = key_angle[0][j];
            end
            psi_pkg::CMD_TICK: begin
                if (dwell_time > 32'hFFFF_FFFF - {8'd0, it.time_value})
                    dwell_time = 32'hFFFF_FFFF;
                else
                    dwell_time = dwell_time + {8'd0, it.time_value};
                if (!hold) begin
                    h    = hdr_tab[pose_state];
                    feet = {it.right_contact, it.left_contact};
                    go   = h.timed ? (dwell_time > {8'd0, h.duration})
                                   : ({1'b0, feet} == h.contact);
                    if (go) begin
                        dwell_time = '0;
                        for (int j = 0; j < NUM_JOINTS; j++)
                            latch_angle[j] = key_local[h.next][j] ? meas_loc[j] : meas_glb[j];
                        pose_state = h.next;
                    end
                end
                h = hdr_tab[pose_state];
                for (int j = 0; j < NUM_JOINTS; j++) begin
                    x2 = key_angle[pose_state][j];
                    x1 = latch_angle[j];
                    r.joint_index_res = 3'(j);
                    r.current_state   = pose_state;
                    r.last            = (j == NUM_JOINTS - 1);
                    if (hold || !h.timed || h.duration == '0)
                        r.target_angle = 16'(x2);
                    else if (x1 == x2)
                        r.target_angle = 16'(x1);
                    else
                        r.target_angle = 16'(lerp_angle(x1, x2, dwell_time, h.duration));
                    joint_targets_q.insert(joint_targets_q.size(), r);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        psi_pkg::t_out_item want;
        if (!i_rst_n) begin
            state_count = 4'd1;
            pose_state  = '0;
            dwell_time  = '0;
            o_fail_count = 0;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                latch_angle[j] = 0;
                meas_loc[j]    = 0;
                meas_glb[j]    = 0;
            end
            joint_targets_q.delete();
        end else begin
            if (o_strobe) begin
                if (joint_targets_q.size() == 0) begin
                    $error("unexpected result: joint %0d angle %0d", o_res.joint_index_res,
                           o_res.target_angle);
                    o_fail_count++;
                end else begin
                    want = joint_targets_q.pop_front();
                    if (o_res.joint_index_res !== want.joint_index_res) begin
                        $error("joint_index_res: expected %0d, got %0d",
                               want.joint_index_res, o_res.joint_index_res);
                        o_fail_count++;
                    end
                    if (o_res.target_angle !== want.target_angle) begin
                        $error("target_angle: expected %0d, got %0d",
                               want.target_angle, o_res.target_angle);
                        o_fail_count++;
                    end
                    if (o_res.current_state !== want.current_state) begin
                        $error("current_state: expected %0d, got %0d",
                               want.current_state, o_res.current_state);
                        o_fail_count++;
                    end
                    if (o_res.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_res.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we)
                state_count = i_cfg_data;
            if (start && !busy)
                advance_pose(i_cmd);
        end
    end

endmodule

// ===== bench/tb_pose_sequencer_interpolator_top.sv =====
`timescale 1ns / 100ps

module tb_pose_sequencer_interpolator_top;

    localparam int NSTATES  = 8;
    localparam int NJOINTS  = 7;
    localparam int SETTLE   = 80;
    localparam int MAX_CYC  = 600000;
    localparam int IN_W     = $bits(psi_pkg::t_in_item);

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    psi_pkg::t_in_item  i_cmd;
    logic               i_cfg_we;
    logic [3:0]         i_cfg_data;
    logic               o_strobe;
    psi_pkg::t_out_item o_res;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    logic               gaps_on;

    pose_sequencer_interpolator_top #(.MAX_STATES(NSTATES), .NUM_JOINTS(NJOINTS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_strobe  (o_strobe),
        .o_res     (o_res)
    );

    psi_scoreboard #(.MAX_STATES(NSTATES), .NUM_JOINTS(NJOINTS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("tb_pose_sequencer_interpolator_top NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic psi_pkg::t_in_item noise_item();
        psi_pkg::t_in_item it;
        it = psi_pkg::t_in_item'(IN_W'({$urandom, $urandom, $urandom}));
        it.angle_a = pick_angle();
        it.angle_b = pick_angle();
        return it;
    endfunction

    // start stays high across back-to-back items; idle bursts drop it
    task automatic send(psi_pkg::t_in_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic put_header(int s, int nxt, int timed, int code, int dur);
        psi_pkg::t_in_item it;
        it = noise_item();
        it.command = psi_pkg::CMD_HDR;
        it.state_index = 3'(s);
        it.next_state = 3'(nxt);
        it.time_based = 1'(timed);
        it.contact_code = 3'(code);
        it.time_value = 24'(dur);
        send(it);
    endtask

    task automatic put_target(int s, int j, logic [15:0] ang, int loc);
        psi_pkg::t_in_item it;
        it = noise_item();
        it.command = psi_pkg::CMD_TGT;
        it.state_index = 3'(s);
        it.joint_index = 3'(j);
        it.angle_a = ang;
        it.local_flag = 1'(loc);
        send(it);
    endtask

    task automatic put_meas(int j, logic [15:0] loc_ang, logic [15:0] glb_ang);
        psi_pkg::t_in_item it;
        it = noise_item();
        it.command = psi_pkg::CMD_MEAS;
        it.joint_index = 3'(j);
        it.angle_a = loc_ang;
        it.angle_b = glb_ang;
        send(it);
    endtask

    task automatic tick(int tv, int lc, int rc);
        psi_pkg::t_in_item it;
        it = noise_item();
        it.command = psi_pkg::CMD_TICK;
        it.time_value = 24'(tv);
        it.left_contact = 1'(lc);
        it.right_contact = 1'(rc);
        send(it);
    endtask

    task automatic other_cmd(logic [2:0] code);
        psi_pkg::t_in_item it;
        it = noise_item();
        it.command = code;
        send(it);
    endtask

    // block may still be finishing a non-result command: let it settle first
    task automatic set_state_count(logic [3:0] v);
        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_item();
        psi_pkg::t_in_item it;
        int                sel;
        it = noise_item();
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            it.command = psi_pkg::CMD_TICK;
            if ($urandom_range(0, 7) != 0)
                it.time_value = 24'($urandom_range(0, 24'h6000));
        end else if (sel < 62) begin
            it.command = psi_pkg::CMD_HDR;
            if ($urandom_range(0, 5) != 0)
                it.time_value = 24'($urandom_range(0, 24'h20000));
            if ($urandom_range(0, 3) != 0)
                it.contact_code = 3'($urandom_range(0, 3));
        end else if (sel < 77) begin
            it.command = psi_pkg::CMD_TGT;
        end else if (sel < 90) begin
            it.command = psi_pkg::CMD_MEAS;
        end else if (sel < 95) begin
            it.command = psi_pkg::CMD_RESTART;
        end else begin
            it.command = 3'($urandom_range(5, 7));
        end
        send(it);
    endtask

    initial begin
        logic [3:0] count_plan [6];
        cycle_count = 0;
        gaps_on     = 1'b1;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 4'd1;
        count_plan  = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        set_state_count(4'd1);

        // fill every table entry so nothing unwritten is ever read
        for (int s = 0; s < NSTATES; s++) begin
            put_header(s, $urandom_range(0, 7), $urandom_range(0, 1),
                       $urandom_range(0, 7), $urandom_range(1, 24'h10000));
            for (int j = 0; j < NJOINTS; j++)
                put_target(s, j, pick_angle(), $urandom_range(0, 1));
        end
        for (int j = 0; j < NJOINTS; j++)
            put_meas(j, pick_angle(), pick_angle());

        // hold mode, extremes, ignored writes, unknown commands
        tick(0, 0, 0);
        tick(24'hFFFFFF, 1, 1);
        put_meas(7, 16'h7FFF, 16'h8000);
        put_target(3, 7, 16'h8000, 1);
        other_cmd(3'd5);
        other_cmd(3'd6);
        other_cmd(3'd7);
        other_cmd(psi_pkg::CMD_RESTART);
        tick(5, 1, 0);

        set_state_count(4'd8);
        put_header(0, 1, 1, 0, 0);           // zero duration: key pose
        tick(1, 0, 0);
        put_header(1, 2, 0, 3, 0);           // contact on both feet
        put_target(2, 0, 16'd100, 1);
        put_meas(0, 16'd100, 16'h8000);      // equal endpoints on joint 0
        put_meas(1, 16'h7FFF, 16'h8000);
        put_target(2, 1, 16'h8000, 0);
        put_header(2, 3, 1, 4, 24'h10000);
        tick(3, 1, 1);
        tick(24'h4000, 0, 1);
        tick(24'h8000, 1, 0);
        put_header(3, 3, 0, 4, 24'h100);     // contact code that never matches
        tick(24'h10000, 1, 1);
        tick(0, 0, 0);

        // hold mode run with large time steps, back to back
        set_state_count(4'd1);
        gaps_on = 1'b0;
        for (int k = 0; k < 20; k++)
            tick(24'hFFFFFF, $urandom_range(0, 1), $urandom_range(0, 1));
        gaps_on = 1'b1;

        for (int p = 0; p < 6; p++) begin
            set_state_count(count_plan[p]);
            if (p == 5)
                gaps_on = 1'b0;
            for (int k = 0; k < 12; k++)
                random_item();
        end

        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_pose_sequencer_interpolator_top OK");
        else
            $display("tb_pose_sequencer_interpolator_top NOT OK");
        $finish;
    end

endmodule
